### rtl/mdd_pkg.sv
// ----------------------------------------------------------------------------
// mdd_pkg
// Shared widths, constants and controller/datapath command type for the
// maximum drawdown tracker.
// ----------------------------------------------------------------------------
package mdd_pkg;

   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DD_BITS    = FRAC_BITS + 1;
   localparam int CNT_BITS   = $clog2(FRAC_BITS);

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS - 1);

   typedef struct packed {
      logic take;   // transaction accepted, update tracking state
      logic start;  // accepted transaction closes the series, latch divider operands
      logic step;   // one quotient bit
      logic load;   // move quotient into output register
   } mdd_cmd_type;

endpackage

### rtl/max_drawdown_tracker_top.sv
// ----------------------------------------------------------------------------
// max_drawdown_tracker_top
// Streaming maximum drawdown; Q1.16 drawdown with its peak and trough on last.
// Throughput: one sample per cycle; stalled from a last sample to its result.
// Result: divided after the last sample, valid once the output is free.
// Reset: synchronous, clears the controller and all tracking state.
// ----------------------------------------------------------------------------
module max_drawdown_tracker_top
   import mdd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [VALUE_BITS-1:0]       req_value,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DD_BITS-1:0]   rsp_drawdown,
   output logic [VALUE_BITS-1:0]       rsp_peak_value,
   output logic [VALUE_BITS-1:0]       rsp_trough_value
);

   mdd_cmd_type cmd;

   mdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mdd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .rsp_drawdown     (rsp_drawdown),
      .rsp_peak_value   (rsp_peak_value),
      .rsp_trough_value (rsp_trough_value)
   );

endmodule

### rtl/mdd_ctrl.sv
// ----------------------------------------------------------------------------
// mdd_ctrl
// Sequencer: accepts samples, runs the fraction divider after the last
// sample of a series and hands the result to the output register.
// ----------------------------------------------------------------------------
module mdd_ctrl
   import mdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mdd_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_last) begin
                  cmd.start = 1'b1;
                  cnt_in    = '0;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/mdd_dpath.sv
// ----------------------------------------------------------------------------
// mdd_dpath
// Running peak / largest drop tracking, radix-2 restoring fraction divider
// and result registers.
// ----------------------------------------------------------------------------
module mdd_dpath
   import mdd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  mdd_cmd_type                 cmd,
   input  logic [VALUE_BITS-1:0]       req_value,
   output logic signed [DD_BITS-1:0]   rsp_drawdown,
   output logic [VALUE_BITS-1:0]       rsp_peak_value,
   output logic [VALUE_BITS-1:0]       rsp_trough_value
);

   // tracking state
   logic [VALUE_BITS-1:0] peak_ff, peak_in;
   logic                  seen_ff, seen_in;
   logic [VALUE_BITS-1:0] bdrop_ff, bdrop_in;
   logic [VALUE_BITS-1:0] bpeak_ff, bpeak_in;
   logic [VALUE_BITS-1:0] btrough_ff, btrough_in;

   // divider
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic [FRAC_BITS-1:0]  quot_ff, quot_in;
   logic                  zero_ff, zero_in;
   logic                  full_ff, full_in;
   logic [VALUE_BITS-1:0] rpeak_ff, rpeak_in;
   logic [VALUE_BITS-1:0] rtrough_ff, rtrough_in;

   // output registers
   logic signed [DD_BITS-1:0] dd_ff, dd_in;
   logic [VALUE_BITS-1:0]     opeak_ff, opeak_in;
   logic [VALUE_BITS-1:0]     otrough_ff, otrough_in;

   logic [VALUE_BITS-1:0] drop;
   logic [VALUE_BITS-1:0] nbdrop, nbpeak, nbtrough, npeak;
   logic [VALUE_BITS:0]   rem2;
   logic                  ge;
   logic [DD_BITS-1:0]    mag;

   // peak / drop update for the incoming sample
   always_comb begin
      drop     = peak_ff - req_value;
      nbdrop   = bdrop_ff;
      nbpeak   = bpeak_ff;
      nbtrough = btrough_ff;
      npeak    = peak_ff;
      if (!seen_ff) begin
         npeak = req_value;
      end else begin
         if (peak_ff > req_value && drop > bdrop_ff) begin
            nbdrop   = drop;
            nbpeak   = peak_ff;
            nbtrough = req_value;
         end
         if (req_value > peak_ff) begin
            npeak = req_value;
         end
      end
   end

   assign rem2 = {rem_ff, 1'b0};
   assign ge   = (rem2 >= {1'b0, den_ff});

   always_comb begin
      if (zero_ff) begin
         mag = '0;
      end else if (full_ff) begin
         mag = DD_BITS'(1) << FRAC_BITS;
      end else begin
         mag = {1'b0, quot_ff};
      end
   end

   always_comb begin
      peak_in    = peak_ff;
      seen_in    = seen_ff;
      bdrop_in   = bdrop_ff;
      bpeak_in   = bpeak_ff;
      btrough_in = btrough_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      quot_in    = quot_ff;
      zero_in    = zero_ff;
      full_in    = full_ff;
      rpeak_in   = rpeak_ff;
      rtrough_in = rtrough_ff;
      dd_in      = dd_ff;
      opeak_in   = opeak_ff;
      otrough_in = otrough_ff;

      if (cmd.take) begin
         if (cmd.start) begin
            // series ends: latch operands, clear tracking for the next one
            peak_in    = '0;
            seen_in    = 1'b0;
            bdrop_in   = '0;
            bpeak_in   = '0;
            btrough_in = '0;
            rem_in     = nbdrop;
            den_in     = nbpeak;
            quot_in    = '0;
            zero_in    = (nbdrop == '0);
            full_in    = (nbdrop >= nbpeak);
            rpeak_in   = nbpeak;
            rtrough_in = nbtrough;
         end else begin
            peak_in    = npeak;
            seen_in    = 1'b1;
            bdrop_in   = nbdrop;
            bpeak_in   = nbpeak;
            btrough_in = nbtrough;
         end
      end

      if (cmd.step) begin
         quot_in = {quot_ff[FRAC_BITS-2:0], ge};
         if (ge) begin
            rem_in = VALUE_BITS'(rem2 - {1'b0, den_ff});
         end else begin
            rem_in = VALUE_BITS'(rem2);
         end
      end

      if (cmd.load) begin
         dd_in      = DD_BITS'(-$signed(mag));
         opeak_in   = zero_ff ? '0 : rpeak_ff;
         otrough_in = zero_ff ? '0 : rtrough_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff    <= '0;
         seen_ff    <= 1'b0;
         bdrop_ff   <= '0;
         bpeak_ff   <= '0;
         btrough_ff <= '0;
      end else begin
         peak_ff    <= peak_in;
         seen_ff    <= seen_in;
         bdrop_ff   <= bdrop_in;
         bpeak_ff   <= bpeak_in;
         btrough_ff <= btrough_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      quot_ff    <= quot_in;
      zero_ff    <= zero_in;
      full_ff    <= full_in;
      rpeak_ff   <= rpeak_in;
      rtrough_ff <= rtrough_in;
      dd_ff      <= dd_in;
      opeak_ff   <= opeak_in;
      otrough_ff <= otrough_in;
   end

   assign rsp_drawdown     = dd_ff;
   assign rsp_peak_value   = opeak_ff;
   assign rsp_trough_value = otrough_ff;

endmodule
